// File: rtl/mtli_pkg.sv
`timescale 1ns / 1ps
// Package for the multi-table linear interpolator.
// Holds default sizes, status and result-source codes, and controller/datapath structs.
package mtli_pkg;

    localparam int TABLE_DEPTH_DEF    = 64;
    localparam int MATERIAL_COUNT_DEF = 4;
    localparam int DATA_WIDTH_DEF     = 32;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [1:0] RES_ZERO   = 2'd0;
    localparam logic [1:0] RES_RDV    = 2'd1;
    localparam logic [1:0] RES_INTERP = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       append_wr;
        logic       rd_en;
        logic       load_prev;
        logic       md_init;
        logic       md_step;
        logic       res_set;
        logic [1:0] res_src;
        logic [1:0] res_stat;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic mat_ok;
        logic empty;
        logic full;
        logic x_le;
        logic x_ge;
        logic x_eq;
        logic out_busy;
    } t_sts;

endpackage

// File: rtl/mtli_datapath.sv
`timescale 1ns / 1ps
// Datapath: request capture, table memories, fill counts, bit-serial muldiv, output register.
// Depends on mtli_pkg.
module mtli_datapath #(
    parameter int TABLE_DEPTH    = 64,
    parameter int MATERIAL_COUNT = 4,
    parameter int DATA_WIDTH     = 32,
    parameter int IW             = 6,
    parameter int CW             = 7,
    parameter int BW             = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mtli_pkg::t_cmd      i_cmd_bus,
    input  logic [IW-1:0]       i_rd_idx,
    input  logic [BW-1:0]       i_md_bit,
    output mtli_pkg::t_sts      o_sts,
    output logic [CW-1:0]       o_fill,
    input  logic                i_cmd,
    input  logic [1:0]          i_material,
    input  logic signed [31:0]  i_point,
    input  logic signed [31:0]  i_sample_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_result_value,
    output logic [1:0]          o_status
);
    import mtli_pkg::*;

    localparam int DW    = DATA_WIDTH;
    localparam int DEPTH = MATERIAL_COUNT * TABLE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW    = (MATERIAL_COUNT > 1) ? $clog2(MATERIAL_COUNT) : 1;
    localparam logic [AW-1:0] TD_A = AW'(TABLE_DEPTH);
    localparam logic [CW-1:0] TD_C = CW'(TABLE_DEPTH);

    logic [DW-1:0] point_mem [DEPTH];
    logic [DW-1:0] value_mem [DEPTH];

    logic          r_cmd;
    logic [1:0]    r_mat;
    logic [DW-1:0] r_x;
    logic [DW-1:0] r_v;
    logic [CW-1:0] r_fill [MATERIAL_COUNT];
    logic [DW-1:0] r_rd_p, r_rd_v;
    logic [DW-1:0] r_prev_p, r_prev_v;
    logic [DW-1:0] r_a, r_b, r_d, r_r, r_v0;
    logic [DW+1:0] r_q;
    logic          r_rising;
    logic [DW-1:0] r_res;
    logic [1:0]    r_stat;
    logic [DW-1:0] r_out_res;
    logic [1:0]    r_out_stat;
    logic          r_out_valid;

    logic          mat_ok;
    logic [MW-1:0] mat_i;
    logic [CW-1:0] fill;
    logic [AW-1:0] base, wr_addr, rd_addr;
    logic          do_wr;
    logic [DW:0]   r2, r2m, r3, r3m;
    logic          c1, c2;
    logic [DW-1:0] interp;

    assign mat_ok  = ({30'd0, r_mat} < 32'(MATERIAL_COUNT));
    assign mat_i   = MW'(r_mat);
    assign fill    = mat_ok ? r_fill[mat_i] : '0;
    assign base    = AW'(r_mat) * TD_A;
    assign wr_addr = base + AW'(fill);
    assign rd_addr = base + AW'(i_rd_idx);
    assign do_wr   = i_cmd_bus.append_wr && mat_ok && (fill < TD_C);

    assign o_fill         = fill;
    assign o_sts.is_query = r_cmd;
    assign o_sts.mat_ok   = mat_ok;
    assign o_sts.empty    = (fill == '0);
    assign o_sts.full     = (fill >= TD_C);
    assign o_sts.x_le     = $signed(r_x) <= $signed(r_rd_p);
    assign o_sts.x_ge     = $signed(r_x) >= $signed(r_rd_p);
    assign o_sts.x_eq     = (r_x == r_rd_p);
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    // one bit of floor(a*b/d), remainder kept below d
    always_comb begin
        r2  = {r_r, 1'b0};
        c1  = (r2 >= {1'b0, r_d});
        r2m = c1 ? (r2 - {1'b0, r_d}) : r2;
        r3  = r2m + {1'b0, r_a};
        c2  = r_b[i_md_bit] && (r3 >= {1'b0, r_d});
        if (!r_b[i_md_bit]) begin
            r3m = r2m;
        end else if (c2) begin
            r3m = r3 - {1'b0, r_d};
        end else begin
            r3m = r3;
        end
    end

    assign interp = r_rising ? (r_v0 + DW'(r_q)) : (r_v0 - DW'(r_q));

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.capture) begin
            r_cmd <= i_cmd;
            r_mat <= i_material;
            r_x   <= DW'($unsigned(i_point));
            r_v   <= DW'($unsigned(i_sample_value));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < MATERIAL_COUNT; m++) begin
                r_fill[m] <= '0;
            end
        end else if (do_wr) begin
            r_fill[mat_i] <= fill + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            point_mem[wr_addr] <= r_x;
            value_mem[wr_addr] <= r_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.rd_en) begin
            r_rd_p <= point_mem[rd_addr];
            r_rd_v <= value_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.load_prev) begin
            r_prev_p <= r_rd_p;
            r_prev_v <= r_rd_v;
        end
        if (i_cmd_bus.md_init) begin
            r_a      <= r_x - r_prev_p;
            r_d      <= r_rd_p - r_prev_p;
            r_rising <= $signed(r_rd_v) >= $signed(r_prev_v);
            r_b      <= ($signed(r_rd_v) >= $signed(r_prev_v)) ? (r_rd_v - r_prev_v)
                                                               : (r_prev_v - r_rd_v);
            r_v0     <= r_prev_v;
            r_r      <= '0;
            r_q      <= '0;
        end else if (i_cmd_bus.md_step) begin
            r_r <= DW'(r3m);
            r_q <= {r_q[DW:0], 1'b0} + (DW+2)'(c1) + (DW+2)'(c2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.res_set) begin
            r_stat <= i_cmd_bus.res_stat;
            case (i_cmd_bus.res_src)
                RES_RDV:    r_res <= r_rd_v;
                RES_INTERP: r_res <= interp;
                default:    r_res <= '0;
            endcase
        end
        if (i_cmd_bus.out_load) begin
            r_out_res  <= r_res;
            r_out_stat <= r_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd_bus.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = 32'(r_out_res);
    assign o_status       = r_out_stat;

endmodule

// File: rtl/mtli_controller.sv
`timescale 1ns / 1ps
// Controller: sequences append, clamp checks, linear search and muldiv steps.
// Depends on mtli_pkg.
module mtli_controller #(
    parameter int DATA_WIDTH = 32,
    parameter int IW         = 6,
    parameter int CW         = 7,
    parameter int BW         = 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mtli_pkg::t_sts i_sts,
    input  logic [CW-1:0]  i_fill,
    output mtli_pkg::t_cmd o_cmd_bus,
    output logic [IW-1:0]  o_rd_idx,
    output logic [BW-1:0]  o_md_bit
);
    import mtli_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_C0   = 4'd2;
    localparam logic [3:0] S_CL   = 4'd3;
    localparam logic [3:0] S_CK   = 4'd4;
    localparam logic [3:0] S_MD   = 4'd5;
    localparam logic [3:0] S_RES  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;

    localparam logic [BW-1:0] BIT_TOP = BW'(DATA_WIDTH - 1);

    logic [3:0]    r_state, n_state;
    logic [IW-1:0] r_k, n_k;
    logic [BW-1:0] r_bit, n_bit;

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_bit     = r_bit;
        o_cmd_bus = '0;
        o_rd_idx  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd_bus.capture = 1'b1;
                    n_state           = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd_bus.res_set = 1'b1;
                o_cmd_bus.res_src = RES_ZERO;
                if (!i_sts.is_query) begin
                    o_cmd_bus.append_wr = 1'b1;
                    o_cmd_bus.res_stat  = (i_sts.mat_ok && !i_sts.full) ? ST_OK : ST_FULL;
                    n_state             = S_FIN;
                end else if (!i_sts.mat_ok || i_sts.empty) begin
                    o_cmd_bus.res_stat = ST_EMPTY;
                    n_state            = S_FIN;
                end else begin
                    o_cmd_bus.res_set = 1'b0;
                    o_cmd_bus.rd_en   = 1'b1;
                    n_state           = S_C0;
                end
            end
            S_C0: begin
                if (i_sts.x_le) begin
                    o_cmd_bus.res_set = 1'b1;
                    o_cmd_bus.res_src = RES_RDV;
                    n_state           = S_FIN;
                end else begin
                    o_cmd_bus.load_prev = 1'b1;
                    o_cmd_bus.rd_en     = 1'b1;
                    o_rd_idx            = IW'(i_fill - CW'(1));
                    n_state             = S_CL;
                end
            end
            S_CL: begin
                if (i_sts.x_ge) begin
                    o_cmd_bus.res_set = 1'b1;
                    o_cmd_bus.res_src = RES_RDV;
                    n_state           = S_FIN;
                end else begin
                    o_cmd_bus.rd_en = 1'b1;
                    o_rd_idx        = IW'(1);
                    n_k             = IW'(1);
                    n_state         = S_CK;
                end
            end
            S_CK: begin
                if (i_sts.x_eq) begin
                    o_cmd_bus.res_set = 1'b1;
                    o_cmd_bus.res_src = RES_RDV;
                    n_state           = S_FIN;
                end else if (i_sts.x_ge) begin
                    o_cmd_bus.load_prev = 1'b1;
                    o_cmd_bus.rd_en     = 1'b1;
                    o_rd_idx            = r_k + IW'(1);
                    n_k                 = r_k + IW'(1);
                end else begin
                    o_cmd_bus.md_init = 1'b1;
                    n_bit             = BIT_TOP;
                    n_state           = S_MD;
                end
            end
            S_MD: begin
                o_cmd_bus.md_step = 1'b1;
                n_bit             = r_bit - BW'(1);
                if (r_bit == '0) begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                o_cmd_bus.res_set = 1'b1;
                o_cmd_bus.res_src = RES_INTERP;
                n_state           = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd_bus.out_load = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_bit <= n_bit;
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_md_bit   = r_bit;

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_bus.out_load |-> !i_sts.out_busy)
        else $error("result loaded over a pending one");

    a_interp_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_bus.md_init |-> (!i_sts.x_ge && r_state == S_CK))
        else $error("interpolation started without an upper entry");

    a_bit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MD && r_bit != '0) |=> (r_state == S_MD && r_bit == $past(r_bit) - BW'(1)))
        else $error("muldiv bit counter out of step");

endmodule

// File: rtl/multi_table_linear_interpolator_unit.sv
`timescale 1ns / 1ps
// Top level of the multi-table linear interpolator.
// Depends on mtli_pkg, mtli_controller and mtli_datapath.
//
// One request at a time. An append goes from S_DEC to S_FIN and waits there
// for the output; a query checks the clamps at both table ends, then searches
// linearly, one memory read per cycle, for the first entry not below the
// query and runs the bit-serial multiply-divide. Clamped and exact hits skip
// the divide. Point and value tables are two single-port-read memories of
// MATERIAL_COUNT*TABLE_DEPTH entries each; fill counts are reset, memories not.
module multi_table_linear_interpolator_unit #(
    parameter int TABLE_DEPTH    = mtli_pkg::TABLE_DEPTH_DEF,
    parameter int MATERIAL_COUNT = mtli_pkg::MATERIAL_COUNT_DEF,
    parameter int DATA_WIDTH     = mtli_pkg::DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cmd,
    input  logic [1:0]         i_material,
    input  logic signed [31:0] i_point,
    input  logic signed [31:0] i_sample_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_result_value,
    output logic [1:0]         o_status
);
    import mtli_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int BW = $clog2(DATA_WIDTH);

    t_cmd          cmd_bus;
    t_sts          sts;
    logic [IW-1:0] rd_idx;
    logic [CW-1:0] fill;
    logic [BW-1:0] md_bit;

    mtli_controller #(
        .DATA_WIDTH (DATA_WIDTH),
        .IW         (IW),
        .CW         (CW),
        .BW         (BW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .i_fill     (fill),
        .o_cmd_bus  (cmd_bus),
        .o_rd_idx   (rd_idx),
        .o_md_bit   (md_bit)
    );

    mtli_datapath #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .MATERIAL_COUNT (MATERIAL_COUNT),
        .DATA_WIDTH     (DATA_WIDTH),
        .IW             (IW),
        .CW             (CW),
        .BW             (BW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_bus      (cmd_bus),
        .i_rd_idx       (rd_idx),
        .i_md_bit       (md_bit),
        .o_sts          (sts),
        .o_fill         (fill),
        .i_cmd          (i_cmd),
        .i_material     (i_material),
        .i_point        (i_point),
        .i_sample_value (i_sample_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

endmodule
